/* rtl/sha1md_pkg.sv */
package sha1md_pkg;

  localparam int unsigned NumDig  = 5;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned BlkByte = 64;
  localparam int unsigned LenPos  = 56;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hEFCD_AB89;
  localparam logic [31:0] H2 = 32'h98BA_DCFE;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hC3D2_E1F0;

  localparam logic [7:0] PadMark = 8'h80;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       sched;
  } buf_ctl_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = H0;
      3'd1:    v = H1;
      3'd2:    v = H2;
      3'd3:    v = H3;
      default: v = H4;
    endcase
    return v;
  endfunction

endpackage

/* rtl/sha1md_if.sv */
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/sha1md_sched.sv */
module sha1md_sched (
  input  logic                clk,
  input  sha1md_pkg::buf_ctl_t ctl,
  output logic [31:0]         w_t
);
  import sha1md_pkg::*;

  logic [511:0] blk;
  logic [31:0]  mix;

  assign w_t = blk[511:480];
  assign mix = blk[511:480] ^ blk[447:416] ^ blk[255:224] ^ blk[95:64];

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      blk <= {blk[503:0], ctl.byte_val};
    end else if (ctl.sched) begin
      blk <= {blk[479:0], mix[30:0], mix[31]};
    end
  end

endmodule

/* rtl/sha1md_round.sv */
module sha1md_round (
  input  sha1md_pkg::work_t cur,
  input  logic [31:0]       w_t,
  input  logic [6:0]        rnd,
  output sha1md_pkg::work_t nxt
);
  import sha1md_pkg::*;

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K3;
    end
  end

  assign nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w_t;
  assign nxt.b = cur.a;
  assign nxt.c = {cur.b[1:0], cur.b[31:2]};
  assign nxt.d = cur.c;
  assign nxt.e = cur.d;

endmodule

/* rtl/sha1md_core.sv */
module sha1md_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_present,
  input  logic                in_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_word,
  output logic [2:0]          out_index,
  output logic                out_last,
  output sha1md_pkg::buf_ctl_t ctl,
  input  logic [31:0]         w_t,
  output sha1md_pkg::work_t   work,
  output logic [6:0]          round_cnt,
  input  sha1md_pkg::work_t   work_next
);
  import sha1md_pkg::*;

  typedef enum logic [2:0] {IDLE, COMPRESS, FOLD, PAD, OUT} state_t;

  state_t      state;
  logic [31:0] chain [NumDig];
  logic [63:0] msg_bits;
  logic [5:0]  blk_pos;
  logic        finishing;
  logic        pad_first;
  logic        spill;
  logic        final_blk;
  logic [2:0]  out_idx;
  logic [7:0]  len_byte [8];
  logic [7:0]  pad_byte;
  logic        in_acc;

  assign in_ready  = (state == IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state == OUT);
  assign out_word  = chain[out_idx];
  assign out_index = out_idx;
  assign out_last  = (out_idx == 3'(NumDig - 1));

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      len_byte[j] = msg_bits[8*j +: 8];
    end
    if (pad_first) begin
      pad_byte = PadMark;
    end else if (spill || (blk_pos < 6'(LenPos))) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_byte[~blk_pos[2:0]];
    end
  end

  always_comb begin
    ctl.shift_byte = 1'b0;
    ctl.byte_val   = pad_byte;
    ctl.sched      = 1'b0;
    if (state == IDLE && in_acc && in_present) begin
      ctl.shift_byte = 1'b1;
      ctl.byte_val   = in_byte;
    end else if (state == PAD) begin
      ctl.shift_byte = 1'b1;
    end else if (state == COMPRESS) begin
      ctl.sched = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      msg_bits  <= '0;
      blk_pos   <= '0;
      round_cnt <= '0;
      finishing <= 1'b0;
      pad_first <= 1'b0;
      spill     <= 1'b0;
      final_blk <= 1'b0;
      out_idx   <= '0;
      for (int i = 0; i < NumDig; i++) begin
        chain[i] <= init_word(3'(i));
      end
    end else begin
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            finishing <= in_end;
            pad_first <= 1'b1;
            spill     <= 1'b0;
            if (in_present) begin
              msg_bits <= msg_bits + 64'd8;
              blk_pos  <= blk_pos + 6'd1;
            end
            if (in_present && blk_pos == 6'(BlkByte - 1)) begin
              work      <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
              round_cnt <= '0;
              final_blk <= 1'b0;
              state     <= COMPRESS;
            end else if (in_end) begin
              state <= PAD;
            end
          end
        end
        COMPRESS: begin
          work      <= work_next;
          round_cnt <= round_cnt + 7'd1;
          if (round_cnt == 7'(Rounds - 1)) begin
            state <= FOLD;
          end
        end
        FOLD: begin
          chain[0] <= chain[0] + work.a;
          chain[1] <= chain[1] + work.b;
          chain[2] <= chain[2] + work.c;
          chain[3] <= chain[3] + work.d;
          chain[4] <= chain[4] + work.e;
          round_cnt <= '0;
          if (final_blk) begin
            out_idx <= '0;
            state   <= OUT;
          end else if (finishing) begin
            state <= PAD;
          end else begin
            state <= IDLE;
          end
        end
        PAD: begin
          blk_pos   <= blk_pos + 6'd1;
          pad_first <= 1'b0;
          if (pad_first) begin
            spill <= (blk_pos >= 6'(LenPos)) && (blk_pos != 6'(BlkByte - 1));
          end else if (blk_pos == 6'(BlkByte - 1)) begin
            spill <= 1'b0;
          end
          if (blk_pos == 6'(BlkByte - 1)) begin
            work      <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
            round_cnt <= '0;
            final_blk <= !pad_first && !spill;
            state     <= COMPRESS;
          end
        end
        OUT: begin
          if (out_ready) begin
            if (out_idx == 3'(NumDig - 1)) begin
              msg_bits  <= '0;
              blk_pos   <= '0;
              finishing <= 1'b0;
              final_blk <= 1'b0;
              out_idx   <= '0;
              for (int i = 0; i < NumDig; i++) begin
                chain[i] <= init_word(3'(i));
              end
              state <= IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/sha1_message_digest_unit.sv */
// SHA-1 digest of a byte stream.
// Channel msg takes one transaction per message byte (byte_present high) and
// marks the end of a message with end_of_message; an end transaction without a
// byte closes the message as it stands, so an empty message is one end marker.
// Channel digest then gives five transactions, word_index 0 (most significant)
// to 4, last_word high on the fifth; after it the unit starts a new message.
// Every 64th byte starts a compression of 80 rounds on the single shared round
// unit, followed by a fold of the round words into the chaining value;
// msg.ready stays low meanwhile. The end marker is followed by the padding
// and length bytes (up to 64, or 72 when padding spills into a second block)
// and by one or two compressions before the first digest word.
// The digest words sit in the chaining registers; while the receiver stalls
// they hold, and msg.ready stays low until the fifth word is taken.
// Reset (rst, synchronous) loads the initial hash words, clears the length
// and block position and leaves the unit ready for a first byte.
module sha1_message_digest_unit (
  input  logic        clk,
  input  logic        rst,
  sha1md_in_if.sink   msg,
  sha1md_out_if.source digest
);
  import sha1md_pkg::*;

  buf_ctl_t    ctl;
  logic [31:0] w_t;
  work_t       work;
  work_t       work_next;
  logic [6:0]  round_cnt;

  sha1md_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w_t (w_t)
  );

  sha1md_round u_round (
    .cur (work),
    .w_t (w_t),
    .rnd (round_cnt),
    .nxt (work_next)
  );

  sha1md_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg.valid),
    .in_ready   (msg.ready),
    .in_byte    (msg.data_byte),
    .in_present (msg.byte_present),
    .in_end     (msg.end_of_message),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .out_word   (digest.digest_word),
    .out_index  (digest.word_index),
    .out_last   (digest.last_word),
    .ctl        (ctl),
    .w_t        (w_t),
    .work       (work),
    .round_cnt  (round_cnt),
    .work_next  (work_next)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> !msg.ready)
    else $error("input ready while digest pending");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> (digest.last_word == (digest.word_index == 3'd4)))
    else $error("last_word out of step with word_index");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    round_cnt <= 7'(Rounds))
    else $error("round counter beyond last round");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    digest.valid && digest.ready && digest.last_word |=> msg.ready && !digest.valid)
    else $error("unit not ready after final digest word");
`endif

endmodule
